// File: design/bcp_pkg.sv
// Shared constants, status codes and hex decode for the buffer command parser.
package bcp_pkg;

  localparam int NIB_W      = 4;
  localparam int ADDR_DIGITS = 8;
  localparam int LEN_DIGITS  = 8;
  localparam int WORD_W     = NIB_W * ADDR_DIGITS;
  localparam int POS_W      = 5;

  localparam logic [POS_W-1:0] POS_TAG_B     = 5'd0;
  localparam logic [POS_W-1:0] POS_INDEX     = 5'd1;
  localparam logic [POS_W-1:0] POS_TAG_A     = 5'd2;
  localparam logic [POS_W-1:0] POS_ADDR_LAST = 5'd10;
  localparam logic [POS_W-1:0] POS_TAG_L     = 5'd11;
  localparam logic [POS_W-1:0] POS_LAST      = 5'd19;

  localparam logic [7:0] CH_UB = 8'h42;  // 'B'
  localparam logic [7:0] CH_UA = 8'h41;  // 'A'
  localparam logic [7:0] CH_UL = 8'h4C;  // 'L'
  localparam logic [7:0] CH_0  = 8'h30;  // '0'
  localparam logic [7:0] CH_9  = 8'h39;  // '9'
  localparam logic [7:0] CH_UF = 8'h46;  // 'F'
  localparam logic [7:0] CH_LA = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF = 8'h66;  // 'f'
  localparam logic [7:0] HEX_TEN = 8'd10;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_TAG_B = 3'd1,
    ST_INDEX = 3'd2,
    ST_TAG_A = 3'd3,
    ST_ADDR  = 3'd4,
    ST_TAG_L = 3'd5,
    ST_LEN   = 3'd6,
    ST_TRUNC = 3'd7
  } status_t;

  typedef struct packed {
    logic             ok;
    logic [NIB_W-1:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] ch);
    hex_t       h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (ch >= CH_0 && ch <= CH_9) begin
      d = ch - CH_0;
      h.ok = 1'b1;
    end else if (ch >= CH_UA && ch <= CH_UF) begin
      d = ch - CH_UA + HEX_TEN;
      h.ok = 1'b1;
    end else if (ch >= CH_LA && ch <= CH_LF) begin
      d = ch - CH_LA + HEX_TEN;
      h.ok = 1'b1;
    end
    h.nib = d[NIB_W-1:0];
    return h;
  endfunction

endpackage

// File: design/buffer_command_parser.sv
// Top level: command framing, checks, digit cell chains and output register.
// The result of a command is registered and valid in the cycle after its 20th
// byte (or a buffer-end byte) is accepted.
// Throughput: one byte per cycle unless an untaken result stalls the input; the
// position counter advances on every accepted byte, digit chains on clean digits.
// Reset clears the byte position, the first-error code and the output valid.
module buffer_command_parser
  import bcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_in,
  input  logic        in_buffer_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_buffer_index,
  output logic [31:0] out_phys_address,
  output logic [31:0] out_phys_length
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  status_t          err_r, err_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;
  logic [NIB_W-1:0] index_o_r, index_o_nxt;
  logic [WORD_W-1:0] addr_o_r, addr_o_nxt;
  logic [WORD_W-1:0] len_o_r, len_o_nxt;

  logic       accept;
  hex_t       hex;
  logic       bad;
  status_t    code;
  logic       idx_en, addr_en, len_en;
  logic       done, trunc;

  logic [NIB_W-1:0] index_q;
  logic [NIB_W-1:0] addr_q [ADDR_DIGITS];
  logic [NIB_W-1:0] len_q  [LEN_DIGITS];
  logic [WORD_W-1:0] addr_word, len_word;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign hex      = hex_decode(in_char_in);

  // checks by position within the command
  always_comb begin
    bad  = 1'b0;
    code = ST_OK;
    priority if (pos_r == POS_TAG_B) begin
      bad  = (in_char_in != CH_UB);
      code = ST_TAG_B;
    end else if (pos_r == POS_INDEX) begin
      bad  = !hex.ok;
      code = ST_INDEX;
    end else if (pos_r == POS_TAG_A) begin
      bad  = (in_char_in != CH_UA);
      code = ST_TAG_A;
    end else if (pos_r <= POS_ADDR_LAST) begin
      bad  = !hex.ok;
      code = ST_ADDR;
    end else if (pos_r == POS_TAG_L) begin
      bad  = (in_char_in != CH_UL);
      code = ST_TAG_L;
    end else begin
      bad  = !hex.ok;
      code = ST_LEN;
    end
  end

  // digits are taken only while the command is still clean
  always_comb begin
    idx_en  = accept && (err_r == ST_OK) && hex.ok && (pos_r == POS_INDEX);
    addr_en = accept && (err_r == ST_OK) && hex.ok &&
              (pos_r > POS_TAG_A) && (pos_r <= POS_ADDR_LAST);
    len_en  = accept && (err_r == ST_OK) && hex.ok && (pos_r > POS_TAG_L);
  end

  bcp_nib_cell u_index_cell (
    .clk      (clk),
    .shift_en (idx_en),
    .nib_in   (hex.nib),
    .nib_out  (index_q)
  );

  for (genvar k = 0; k < ADDR_DIGITS; k++) begin : g_addr
    if (k == 0) begin : g_head
      bcp_nib_cell u_cell (
        .clk(clk), .shift_en(addr_en), .nib_in(hex.nib), .nib_out(addr_q[k])
      );
    end else begin : g_body
      bcp_nib_cell u_cell (
        .clk(clk), .shift_en(addr_en), .nib_in(addr_q[k-1]), .nib_out(addr_q[k])
      );
    end
  end

  for (genvar k = 0; k < LEN_DIGITS; k++) begin : g_len
    if (k == 0) begin : g_head
      bcp_nib_cell u_cell (
        .clk(clk), .shift_en(len_en), .nib_in(hex.nib), .nib_out(len_q[k])
      );
    end else begin : g_body
      bcp_nib_cell u_cell (
        .clk(clk), .shift_en(len_en), .nib_in(len_q[k-1]), .nib_out(len_q[k])
      );
    end
  end

  always_comb begin
    for (int k = 0; k < ADDR_DIGITS; k++) addr_word[NIB_W*k +: NIB_W] = addr_q[k];
    for (int k = 0; k < LEN_DIGITS; k++)  len_word[NIB_W*k +: NIB_W]  = len_q[k];
  end

  always_comb begin
    err_nxt       = err_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    index_o_nxt   = index_o_r;
    addr_o_nxt    = addr_o_r;
    len_o_nxt     = len_o_r;
    done          = accept && (pos_r == POS_LAST);
    trunc         = accept && !done && in_buffer_end;

    if (accept && err_r == ST_OK && bad) err_nxt = code;

    if (done) begin
      out_valid_nxt = 1'b1;
      status_nxt    = err_nxt;
      // last length digit joins straight from the decoder
      if (err_nxt == ST_OK) begin
        index_o_nxt = index_q;
        addr_o_nxt  = addr_word;
        len_o_nxt   = {len_word[WORD_W-NIB_W-1:0], hex.nib};
      end else begin
        index_o_nxt = '0;
        addr_o_nxt  = '0;
        len_o_nxt   = '0;
      end
    end else if (trunc) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_TRUNC;
      index_o_nxt   = '0;
      addr_o_nxt    = '0;
      len_o_nxt     = '0;
    end

    if (done || trunc) begin
      pos_nxt = '0;
      err_nxt = ST_OK;
    end else if (accept) begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    index_o_r <= index_o_nxt;
    addr_o_r  <= addr_o_nxt;
    len_o_r   <= len_o_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_buffer_index = index_o_r;
  assign out_phys_address = addr_o_r;
  assign out_phys_length  = len_o_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("byte position past end of command");

  a_clean_start: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == POS_TAG_B |-> err_r == ST_OK)
    else $error("error code carried into a new command");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (pos_r == POS_LAST || in_buffer_end)) |=> out_valid_r && pos_r == POS_TAG_B)
    else $error("command end gave no result");

  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_OK) |->
      (index_o_r == '0 && addr_o_r == '0 && len_o_r == '0))
    else $error("nonzero payload with error status");

endmodule

// File: design/bcp_nib_cell.sv
// One hex digit cell of a shifting accumulator chain.
module bcp_nib_cell
  import bcp_pkg::*;
(
  input  logic             clk,
  input  logic             shift_en,
  input  logic [NIB_W-1:0] nib_in,
  output logic [NIB_W-1:0] nib_out
);

  logic [NIB_W-1:0] nib_r;
  logic [NIB_W-1:0] nib_nxt;

  assign nib_nxt = shift_en ? nib_in : nib_r;

  always_ff @(posedge clk) begin
    nib_r <= nib_nxt;
  end

  assign nib_out = nib_r;

endmodule

// File: tb/buffer_command_parser_tb.sv
// Testbench for buffer_command_parser: directed command table, then random streams vs a predictor.
module buffer_command_parser_tb;
  import bcp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_WORDS = 1550;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int CMD_BYTES    = 20;

  typedef struct packed {
    status_t     status;
    logic [3:0]  index;
    logic [31:0] addr;
    logic [31:0] len;
  } cmd_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_in = 8'h00;
  logic        in_buffer_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [3:0]  out_buffer_index;
  logic [31:0] out_phys_address;
  logic [31:0] out_phys_length;

  buffer_command_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_in       (in_char_in),
    .in_buffer_end    (in_buffer_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_buffer_index (out_buffer_index),
    .out_phys_address (out_phys_address),
    .out_phys_length  (out_phys_length)
  );

  // Parser shadow state
  logic [4:0]  cmd_pos = '0;
  logic [3:0]  cmd_index = '0;
  logic [31:0] cmd_addr = '0;
  logic [31:0] cmd_len = '0;
  status_t     cmd_err = ST_OK;

  cmd_result_t pending_results[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          words_sent = 0;
  int          idle_pct = 30;

  // Directed command table
  string       row_text[$];
  bit          row_end[$];
  bit          row_typed[$];
  cmd_result_t row_want[$];

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit hex_nibble(input logic [7:0] ch, output logic [3:0] nib);
    nib = 4'h0;
    if (ch >= CH_0 && ch <= CH_9) begin
      nib = ch[3:0];
      return 1'b1;
    end
    if ((ch >= CH_UA && ch <= CH_UF) || (ch >= CH_LA && ch <= CH_LF)) begin
      nib = ch[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return CH_0 + {4'h0, nib};
    return ($urandom_range(1) ? CH_UA : CH_LA) + {4'h0, nib} - 8'd10;
  endfunction

  // Advance the shadow parser by one byte; returns 1 when a command result is due.
  function automatic bit parse_byte(input logic [7:0] ch, input logic last,
                                    output cmd_result_t res);
    logic [3:0] nib;
    bit         is_hex;
    is_hex = hex_nibble(ch, nib);
    res = '0;
    if (cmd_err == ST_OK) begin
      if (cmd_pos == POS_TAG_B) begin
        if (ch != CH_UB) cmd_err = ST_TAG_B;
      end else if (cmd_pos == POS_INDEX) begin
        if (is_hex) cmd_index = nib;
        else cmd_err = ST_INDEX;
      end else if (cmd_pos == POS_TAG_A) begin
        if (ch != CH_UA) cmd_err = ST_TAG_A;
      end else if (cmd_pos <= POS_ADDR_LAST) begin
        if (is_hex) cmd_addr = {cmd_addr[27:0], nib};
        else cmd_err = ST_ADDR;
      end else if (cmd_pos == POS_TAG_L) begin
        if (ch != CH_UL) cmd_err = ST_TAG_L;
      end else begin
        if (is_hex) cmd_len = {cmd_len[27:0], nib};
        else cmd_err = ST_LEN;
      end
    end
    if (cmd_pos != POS_LAST && !last) begin
      cmd_pos = cmd_pos + 5'd1;
      return 1'b0;
    end
    if (cmd_pos != POS_LAST) begin
      res.status = ST_TRUNC;
    end else if (cmd_err != ST_OK) begin
      res.status = cmd_err;
    end else begin
      res.status = ST_OK;
      res.index  = cmd_index;
      res.addr   = cmd_addr;
      res.len    = cmd_len;
    end
    cmd_pos   = '0;
    cmd_index = '0;
    cmd_addr  = '0;
    cmd_len   = '0;
    cmd_err   = ST_OK;
    return 1'b1;
  endfunction

  task automatic add_row(input string text, input bit end_flag, input bit typed,
                         input status_t st, input logic [3:0] ix,
                         input logic [31:0] ad, input logic [31:0] ln);
    cmd_result_t w;
    w.status = st;
    w.index  = ix;
    w.addr   = ad;
    w.len    = ln;
    row_text.push_back(text);
    row_end.push_back(end_flag);
    row_typed.push_back(typed);
    row_want.push_back(w);
  endtask

  // Offer one word; hold it until accepted, then update the expectations.
  task automatic send_word(input logic [7:0] ch, input logic last, input bit typed,
                           input cmd_result_t want);
    cmd_result_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_char_in <= 8'($urandom);
      in_buffer_end <= 1'($urandom);
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_char_in    <= ch;
    in_buffer_end <= last;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (parse_byte(ch, last, res)) pending_results.push_back(typed ? want : res);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on %s at cycle %0d: got %0h, expected %0h",
               field, cycle_count, got, want);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("buffer_command_parser_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    cmd_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {29'h0, out_status}, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_status != want.status)
          report_mismatch("status", {29'h0, out_status}, {29'h0, want.status});
        if (out_buffer_index != want.index)
          report_mismatch("buffer_index", {28'h0, out_buffer_index}, {28'h0, want.index});
        if (out_phys_address != want.addr)
          report_mismatch("phys_address", out_phys_address, want.addr);
        if (out_phys_length != want.len)
          report_mismatch("phys_length", out_phys_length, want.len);
      end
    end
  end

  initial begin
    logic [7:0]  cmd_bytes [CMD_BYTES];
    cmd_result_t none;
    string       text;
    int          kind;
    int          count;
    int          spot;
    bit          paused;
    bit          zero_digits;

    none   = '0;
    paused = 1'b0;

    add_row("B0A00000000L00000000", 1'b0, 1'b1, ST_OK, 4'h0, 32'h0, 32'h0);
    add_row("BFAFFFFFFFFLFFFFFFFF", 1'b0, 1'b1, ST_OK, 4'hF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add_row("BfAffffffffLffffffff", 1'b0, 1'b1, ST_OK, 4'hF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add_row("B9A12345678L9abcdef0", 1'b1, 1'b0, ST_OK, 4'h0, 32'h0, 32'h0);
    add_row("BaA0aB1cD2eLF3e4D5c6", 1'b0, 1'b0, ST_OK, 4'h0, 32'h0, 32'h0);
    add_row("X0A00000000L00000000", 1'b0, 1'b1, ST_TAG_B, 4'h0, 32'h0, 32'h0);
    add_row("BgA00000000L00000000", 1'b0, 1'b1, ST_INDEX, 4'h0, 32'h0, 32'h0);
    add_row("B@A00000000L00000000", 1'b0, 1'b1, ST_INDEX, 4'h0, 32'h0, 32'h0);
    add_row("B`A00000000L00000000", 1'b0, 1'b1, ST_INDEX, 4'h0, 32'h0, 32'h0);
    add_row("B0Z00000000L00000000", 1'b0, 1'b1, ST_TAG_A, 4'h0, 32'h0, 32'h0);
    add_row("B0A0000G000L00000000", 1'b0, 1'b1, ST_ADDR, 4'h0, 32'h0, 32'h0);
    add_row("B0A0000000:L00000000", 1'b0, 1'b1, ST_ADDR, 4'h0, 32'h0, 32'h0);
    add_row("B0A00000000M00000000", 1'b0, 1'b1, ST_TAG_L, 4'h0, 32'h0, 32'h0);
    add_row("B0A00000000L0000/000", 1'b0, 1'b1, ST_LEN, 4'h0, 32'h0, 32'h0);
    add_row("B0A00000000L0000000g", 1'b1, 1'b1, ST_LEN, 4'h0, 32'h0, 32'h0);
    // several bad checks: only the first one counts
    add_row("b/Zxxxxxxxx*yyyyyyyy", 1'b0, 1'b1, ST_TAG_B, 4'h0, 32'h0, 32'h0);
    add_row("B1Azzzzzzzz*yyyyyyyy", 1'b0, 1'b1, ST_ADDR, 4'h0, 32'h0, 32'h0);
    add_row("B", 1'b1, 1'b1, ST_TRUNC, 4'h0, 32'h0, 32'h0);
    add_row("B3A12", 1'b1, 1'b1, ST_TRUNC, 4'h0, 32'h0, 32'h0);
    add_row("XQ", 1'b1, 1'b1, ST_TRUNC, 4'h0, 32'h0, 32'h0);
    add_row("B7A89abcdefL0123456", 1'b1, 1'b1, ST_TRUNC, 4'h0, 32'h0, 32'h0);
    add_row("B5A0123CDEFLabcd4567", 1'b0, 1'b0, ST_OK, 4'h0, 32'h0, 32'h0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (row_text[r]) begin
      text = row_text[r];
      for (int i = 0; i < text.len(); i++)
        send_word(text[i], (i == text.len() - 1) && (row_end[r] || text.len() < CMD_BYTES),
                  row_typed[r], row_want[r]);
    end

    while (words_sent < TARGET_WORDS) begin
      idle_pct = (words_sent >= 500 && words_sent < 750) ? 0 : 30;

      if (!paused && words_sent >= 1000) begin
        // drain every result before going on
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end

      // realign to a command boundary
      if (cmd_pos != '0) send_word(8'($urandom), 1'b1, 1'b0, none);

      kind = $urandom_range(99);
      if (kind >= 87 && kind < 95) begin
        count = $urandom_range(1, 25);
        for (int i = 0; i < count; i++)
          send_word(8'($urandom), $urandom_range(99) < 5, 1'b0, none);
      end else begin
        zero_digits = $urandom_range(1);
        for (int i = 0; i < CMD_BYTES; i++) begin
          if (kind >= 95) cmd_bytes[i] = zero_digits ? CH_0 : hex_char(4'hF);
          else cmd_bytes[i] = hex_char(4'($urandom));
        end
        cmd_bytes[POS_TAG_B] = CH_UB;
        cmd_bytes[POS_TAG_A] = CH_UA;
        cmd_bytes[POS_TAG_L] = CH_UL;
        count = CMD_BYTES;
        if (kind >= 60 && kind < 75) begin
          spot = $urandom_range(CMD_BYTES - 1);
          // hit each hex range border as often as an arbitrary byte
          case ($urandom_range(6))
            0: cmd_bytes[spot] = 8'($urandom);
            1: cmd_bytes[spot] = 8'h2F;
            2: cmd_bytes[spot] = 8'h3A;
            3: cmd_bytes[spot] = 8'h40;
            4: cmd_bytes[spot] = 8'h47;
            5: cmd_bytes[spot] = 8'h60;
            default: cmd_bytes[spot] = 8'h67;
          endcase
        end else if (kind >= 75 && kind < 87) begin
          count = $urandom_range(1, CMD_BYTES - 1);
        end
        for (int i = 0; i < count; i++)
          send_word(cmd_bytes[i],
                    (i == count - 1) && (count < CMD_BYTES || $urandom_range(99) < 10),
                    1'b0, none);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("buffer_command_parser_tb: PASS");
    end else begin
      $display("buffer_command_parser_tb: FAIL");
    end
    $finish;
  end

endmodule
